### sv/segment_descriptor_table_assert.svh
// Assertion macros for the segment descriptor table.
`ifndef SEGMENT_DESCRIPTOR_TABLE_ASSERT_SVH
`define SEGMENT_DESCRIPTOR_TABLE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define SDT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define SDT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/sdt_pkg.sv
// Types and constants shared by the segment descriptor table modules.
`timescale 1ns / 1ps
package sdt_pkg;

   localparam logic [1:0] KIND_WRITE_OLD = 2'd0;
   localparam logic [1:0] KIND_WRITE_NEW = 2'd1;
   localparam logic [1:0] KIND_TRANSLATE = 2'd2;

   localparam logic [1:0] STATUS_OK           = 2'd0;
   localparam logic [1:0] STATUS_BAD_WRITE    = 2'd1;
   localparam logic [1:0] STATUS_BAD_SELECTOR = 2'd2;

   localparam logic [1:0] CONTENTS_DATA       = 2'd0;
   localparam logic [1:0] CONTENTS_CONFORMING = 2'd3;

   localparam logic [2:0] SEL_LOW_REQUIRED = 3'b111;
   localparam logic [2:0] DESC_FIXED_BITS  = 3'b111;
   localparam logic [11:0] PAGE_FILL       = 12'hfff;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] byte_count;
      logic [31:0] entry_index;
      logic [15:0] selector;
      logic [31:0] address;
      logic [19:0] limit_value;
      logic [1:0]  contents;
      logic        no_write;
      logic        operand_32;
      logic        page_granular;
      logic        absent;
      logic        useable;
   } sdt_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] linear_address;
      logic        limit_exceeded;
      logic        no_table_warning;
   } sdt_rsp_type;

   typedef struct packed {
      logic clear;
      logic capture;
      logic execute;
   } sdt_cmd_type;

   typedef struct packed {
      logic clear_done;
   } sdt_stat_type;

endpackage

### sv/sdt_ctrl.sv
// Controller for the segment descriptor table: clearing pass and beat sequencing.
`timescale 1ns / 1ps
module sdt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  sdt_pkg::sdt_stat_type stat,
   output sdt_pkg::sdt_cmd_type  cmd
);
   import sdt_pkg::*;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE) || ((state_ff == S_RESP) && rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.clear   = (state_ff == S_CLEAR);
      cmd.capture = req_valid && req_ready;
      cmd.execute = (state_ff == S_EXEC);
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (stat.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in     = S_RESP;
            rsp_valid_in = 1'b1;
         end
         S_RESP: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = req_valid ? S_EXEC : S_IDLE;
            end
         end
         default: begin
            state_in     = S_CLEAR;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### sv/sdt_dpath.sv
// Datapath for the segment descriptor table: descriptor memory, packing and translation.
`timescale 1ns / 1ps
module sdt_dpath #(
   parameter int TABLE_ENTRIES = 8192,
   parameter int REQUEST_BYTES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sdt_pkg::sdt_req_type req_data,
   input  sdt_pkg::sdt_cmd_type cmd,
   output sdt_pkg::sdt_stat_type stat,
   output sdt_pkg::sdt_rsp_type rsp_data
);
   import sdt_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   logic [63:0]      table_mem [TABLE_ENTRIES];
   logic [IDX_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic             present_ff, present_in;
   sdt_req_type      req_ff;
   logic [63:0]      rd_ff;
   logic             in_range_ff;
   sdt_rsp_type      rsp_ff, rsp_in;

   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [63:0]      mem_wdata;
   logic [IDX_W-1:0] rd_addr;
   logic             is_write, old_mode, write_ok, clear_entry;
   logic [31:0]      word1, word2;
   logic [31:0]      rd_w1, rd_w2;
   logic [31:0]      base, limit_eff;
   logic [19:0]      limit_raw;

   assign rd_addr = req_data.selector[3 +: IDX_W];

   always_comb begin
      old_mode = (req_ff.kind == KIND_WRITE_OLD);
      is_write = (req_ff.kind == KIND_WRITE_OLD) || (req_ff.kind == KIND_WRITE_NEW);
      write_ok = is_write
               && (req_ff.byte_count == 16'(REQUEST_BYTES))
               && (req_ff.entry_index < 32'(TABLE_ENTRIES))
               && !((req_ff.contents == CONTENTS_CONFORMING)
                    && (old_mode || !req_ff.absent));
      clear_entry = (req_ff.address == '0) && (req_ff.limit_value == '0)
                 && (old_mode || ((req_ff.contents == CONTENTS_DATA)
                                  && req_ff.no_write && !req_ff.operand_32
                                  && !req_ff.page_granular && req_ff.absent
                                  && !req_ff.useable));
      word1 = {req_ff.address[15:0], req_ff.limit_value[15:0]};
      word2 = {req_ff.address[31:24], req_ff.page_granular, req_ff.operand_32, 1'b0,
               req_ff.useable && !old_mode, req_ff.limit_value[19:16],
               !req_ff.absent, DESC_FIXED_BITS, req_ff.contents,
               !req_ff.no_write, 1'b0, req_ff.address[23:16]};
   end

   always_comb begin
      rd_w1     = rd_ff[31:0];
      rd_w2     = rd_ff[63:32];
      base      = '0;
      limit_eff = '0;
      limit_raw = {rd_w2[19:16], rd_w1[15:0]};
      if (present_ff && in_range_ff) begin
         base      = {rd_w2[31:24], rd_w2[7:0], rd_w1[31:16]};
         limit_eff = rd_w2[23] ? {limit_raw, PAGE_FILL} : {12'd0, limit_raw};
      end
   end

   always_comb begin
      rsp_in = '0;
      unique case (req_ff.kind) inside
         KIND_WRITE_OLD, KIND_WRITE_NEW: begin
            rsp_in.status = write_ok ? STATUS_OK : STATUS_BAD_WRITE;
         end
         KIND_TRANSLATE: begin
            if (req_ff.selector[2:0] != SEL_LOW_REQUIRED) begin
               rsp_in.status = STATUS_BAD_SELECTOR;
            end else begin
               rsp_in.status           = STATUS_OK;
               rsp_in.linear_address   = base + req_ff.address;
               rsp_in.limit_exceeded   = (req_ff.address >= limit_eff);
               rsp_in.no_table_warning = !present_ff;
            end
         end
         default: begin
            rsp_in.status = STATUS_BAD_WRITE;
         end
      endcase
   end

   always_comb begin
      mem_we     = cmd.clear || (cmd.execute && write_ok);
      mem_waddr  = cmd.clear ? clr_cnt_ff : req_ff.entry_index[IDX_W-1:0];
      mem_wdata  = (cmd.clear || clear_entry) ? 64'd0 : {word2, word1};
      present_in = present_ff || (cmd.execute && write_ok);
      clr_cnt_in = cmd.clear ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
      stat.clear_done = (clr_cnt_ff == IDX_W'(TABLE_ENTRIES - 1));
   end

   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.capture) begin
         rd_ff <= table_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff      <= req_data;
         in_range_ff <= (32'(req_data.selector[15:3]) < 32'(TABLE_ENTRIES));
      end
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         present_ff <= 1'b0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
         present_ff <= present_in;
      end
   end

endmodule

### sv/segment_descriptor_table.sv
// Top level of the segment descriptor table.
//
// Request channel (req_valid, req_ready, req_data) takes one beat per item: a
// descriptor write in old or new mode, or a segment translation. Response
// channel (rsp_valid, rsp_ready, rsp_data) returns exactly one beat per item,
// in order.
// After a request beat is taken the controller enters its execute state, which
// packs a written descriptor into the memory or decodes the entry that the
// registered read fetched for a translation; rsp_valid then rises from its
// register. A new request beat is taken only while idle or as the waiting
// response leaves.
// After reset the block sweeps all TABLE_ENTRIES entries (8192 by default) of
// the descriptor memory to zero, one entry a cycle; req_ready stays low
// during the sweep.
// When the receiver stalls, the response holds in its output register and the
// next request beat is taken in the cycle the waiting response leaves.
`timescale 1ns / 1ps
module segment_descriptor_table #(
   parameter int TABLE_ENTRIES = 8192,
   parameter int REQUEST_BYTES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sdt_pkg::sdt_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sdt_pkg::sdt_rsp_type rsp_data
);
   import sdt_pkg::*;

   sdt_cmd_type  cmd;
   sdt_stat_type stat;

   sdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sdt_dpath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .REQUEST_BYTES (REQUEST_BYTES)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

`include "segment_descriptor_table_assert.svh"

   `SDT_ASSERT_SAME(a_no_req_in_clear, cmd.clear, !req_ready, "request taken during clear")
   `SDT_ASSERT_NEXT(a_req_then_exec, req_valid && req_ready, cmd.execute, "no execute after beat")
   `SDT_ASSERT_NEXT(a_exec_then_rsp, cmd.execute, rsp_valid, "no response after execute")
   `SDT_ASSERT_NEXT(a_rsp_once, rsp_valid && rsp_ready, !rsp_valid, "response repeated")

endmodule

### dv/testbench.sv
// Self-checking testbench for the segment descriptor table: write and translate beats.
`timescale 1ns / 1ps
module testbench;
   import sdt_pkg::*;

   localparam int TABLE_SIZE   = 8192;
   localparam int REQUEST_SIZE = 16;
   localparam int HOT_COUNT    = 16;
   localparam int RANDOM_ITEMS = 2000;
   localparam int CALM_TAIL    = 300;
   localparam int TAIL_CYCLES  = 20;
   localparam int CYCLE_LIMIT  = 250000;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   class descriptor_scoreboard;
      bit [63:0]   descriptors [TABLE_SIZE];
      bit          table_present;
      sdt_rsp_type expected_q[$];
      int          mismatches;
      int          writes_ok;
      int          rejected;
      int          translations;
      int          over_limit;
      int          no_table;

      function automatic logic [63:0] pack_descriptor(sdt_req_type r, bit legacy);
         logic [31:0] lo;
         logic [31:0] hi;
         lo = {r.address[15:0], r.limit_value[15:0]};
         hi = {r.address[31:24], r.page_granular, r.operand_32, 1'b0,
               legacy ? 1'b0 : r.useable, r.limit_value[19:16], !r.absent,
               DESC_FIXED_BITS, r.contents, !r.no_write, 1'b0, r.address[23:16]};
         return {hi, lo};
      endfunction

      function automatic sdt_rsp_type compute_outcome(sdt_req_type r);
         sdt_rsp_type o;
         bit          legacy;
         bit          wipe;
         logic [63:0] d;
         logic [31:0] seg_base;
         logic [31:0] seg_limit;
         o = '0;
         o.status = STATUS_OK;
         legacy = (r.kind == KIND_WRITE_OLD);
         case (r.kind)
            KIND_WRITE_OLD, KIND_WRITE_NEW: begin
               if (r.byte_count != REQUEST_SIZE || r.entry_index >= TABLE_SIZE ||
                   (r.contents == CONTENTS_CONFORMING && (legacy || !r.absent))) begin
                  o.status = STATUS_BAD_WRITE;
               end else begin
                  table_present = 1'b1;
                  wipe = (r.address == '0) && (r.limit_value == '0) &&
                         (legacy || (r.contents == CONTENTS_DATA && r.no_write &&
                          !r.operand_32 && !r.page_granular && r.absent &&
                          !r.useable));
                  descriptors[r.entry_index[12:0]] = wipe ? '0 : pack_descriptor(r, legacy);
               end
            end
            KIND_TRANSLATE: begin
               if (r.selector[2:0] != SEL_LOW_REQUIRED) begin
                  o.status = STATUS_BAD_SELECTOR;
               end else begin
                  seg_base  = '0;
                  seg_limit = '0;
                  if (!table_present) begin
                     o.no_table_warning = 1'b1;
                  end else begin
                     d = descriptors[r.selector[15:3]];
                     seg_base  = {d[63:56], d[39:32], d[31:16]};
                     seg_limit = {12'd0, d[51:48], d[15:0]};
                     if (d[55]) seg_limit = {seg_limit[19:0], PAGE_FILL};
                  end
                  o.limit_exceeded = (r.address >= seg_limit);
                  o.linear_address = seg_base + r.address;
               end
            end
            default: begin
               o.status = STATUS_BAD_WRITE;
            end
         endcase
         return o;
      endfunction

      function void note_request(sdt_req_type r);
         sdt_rsp_type o;
         o = compute_outcome(r);
         expected_q.push_back(o);
         if (r.kind == KIND_TRANSLATE && o.status == STATUS_OK) begin
            translations++;
            over_limit += o.limit_exceeded;
            no_table += o.no_table_warning;
         end else if (o.status == STATUS_OK) begin
            writes_ok++;
         end else begin
            rejected++;
         end
      endfunction

      function void check_response(sdt_rsp_type got);
         sdt_rsp_type want;
         if (expected_q.size() == 0) begin
            $error("response beat with nothing outstanding");
            mismatches++;
            return;
         end
         want = expected_q.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
         end
         if (got.linear_address !== want.linear_address) begin
            $error("linear_address: expected %h, got %h",
                   want.linear_address, got.linear_address);
            mismatches++;
         end
         if (got.limit_exceeded !== want.limit_exceeded) begin
            $error("limit_exceeded: expected %0b, got %0b",
                   want.limit_exceeded, got.limit_exceeded);
            mismatches++;
         end
         if (got.no_table_warning !== want.no_table_warning) begin
            $error("no_table_warning: expected %0b, got %0b",
                   want.no_table_warning, got.no_table_warning);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   sdt_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready;
   sdt_rsp_type rsp_data;

   descriptor_scoreboard sb = new;
   logic [31:0] hot_entries [HOT_COUNT];
   bit          calm = 1'b0;
   int          cycles = 0;

   segment_descriptor_table u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding",
                  cycles, sb.pending());
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
   end

   initial begin
      int stall;
      stall = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready = 1'b0;
            stall--;
         end else begin
            rsp_ready = 1'b1;
            if (!calm && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 4);
         end
      end
   end

   task automatic send_beat(input sdt_req_type item);
      @(negedge clock);
      req_valid = 1'b1;
      req_data  = item;
      do @(posedge clock); while (!req_ready);
      sb.note_request(item);
   endtask

   task automatic pause_sender(input int gap);
      @(negedge clock);
      req_valid = 1'b0;
      repeat (gap - 1) @(negedge clock);
   endtask

   task automatic drain_responses();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic sdt_req_type write_req(logic [1:0] kind, logic [31:0] entry,
                                             logic [31:0] base, logic [19:0] lim);
      sdt_req_type r;
      r = '0;
      r.kind         = kind;
      r.byte_count   = 16'(REQUEST_SIZE);
      r.entry_index  = entry;
      r.address      = base;
      r.limit_value  = lim;
      r.contents     = CONTENTS_DATA;
      return r;
   endfunction

   function automatic sdt_req_type xlate_req(logic [12:0] index, logic [31:0] offset);
      sdt_req_type r;
      r = '0;
      r.kind     = KIND_TRANSLATE;
      r.selector = {index, SEL_LOW_REQUIRED};
      r.address  = offset;
      return r;
   endfunction

   function automatic sdt_req_type random_request();
      sdt_req_type item;
      int          roll;
      roll = $urandom_range(0, 99);
      item.kind         = KIND_TRANSLATE;
      item.byte_count   = 16'($urandom);
      item.entry_index  = $urandom;
      item.selector     = 16'($urandom);
      item.address      = $urandom;
      item.limit_value  = 20'($urandom);
      item.contents     = 2'($urandom);
      {item.no_write, item.operand_32, item.page_granular,
       item.absent, item.useable} = 5'($urandom);
      if (roll < 42) begin
         item.kind = $urandom_range(0, 1) ? KIND_WRITE_NEW : KIND_WRITE_OLD;
         item.byte_count   = 16'(REQUEST_SIZE);
         item.entry_index  = hot_entries[$urandom_range(0, HOT_COUNT - 1)];
         if (item.contents == CONTENTS_CONFORMING) begin
            if (item.kind == KIND_WRITE_OLD) item.contents = CONTENTS_DATA;
            else item.absent = 1'b1;
         end
         if ($urandom_range(0, 3) == 0) item.limit_value = 20'($urandom_range(0, 'hff));
         if ($urandom_range(0, 9) == 0) begin
            item.address     = '0;
            item.limit_value = '0;
            if ($urandom_range(0, 1)) begin
               item.contents = CONTENTS_DATA;
               {item.no_write, item.operand_32, item.page_granular,
                item.absent, item.useable} = 5'b10010;
            end
         end
      end else if (roll < 90) begin
         item.selector = {hot_entries[$urandom_range(0, HOT_COUNT - 1)][12:0],
                          SEL_LOW_REQUIRED};
         case ($urandom_range(0, 2))
            0: item.address = $urandom_range(0, 'hfff);
            1: item.address = $urandom_range(0, 'hfffff);
            default: ;
         endcase
      end else begin
         case ($urandom_range(0, 4))
            0: item.kind = KIND_UNUSED;
            1: item.kind = $urandom_range(0, 1) ? KIND_WRITE_NEW : KIND_WRITE_OLD;
            2: begin
               item.kind       = $urandom_range(0, 1) ? KIND_WRITE_NEW : KIND_WRITE_OLD;
               item.byte_count = 16'(REQUEST_SIZE);
            end
            3: ;
            default: begin
               item.kind         = KIND_WRITE_OLD;
               item.byte_count   = 16'(REQUEST_SIZE);
               item.entry_index  = hot_entries[$urandom_range(0, HOT_COUNT - 1)];
               item.contents     = CONTENTS_CONFORMING;
            end
         endcase
      end
      return item;
   endfunction

   initial begin
      sdt_req_type t;
      for (int i = 0; i < HOT_COUNT; i++) hot_entries[i] = $urandom_range(0, TABLE_SIZE - 1);
      hot_entries[0] = 0;
      hot_entries[1] = TABLE_SIZE - 1;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_beat(xlate_req(13'd5, 32'd0));
      t = xlate_req(13'd0, 32'd0);
      t.selector = 16'h0000;
      send_beat(t);
      t = '0;
      t.kind = KIND_UNUSED;
      send_beat(t);
      t = write_req(KIND_WRITE_OLD, 32'd4, 32'h1000, 20'h100);
      t.byte_count = 16'(REQUEST_SIZE - 1);
      send_beat(t);
      t.byte_count = '0;
      send_beat(t);
      send_beat(write_req(KIND_WRITE_NEW, TABLE_SIZE, 32'h1000, 20'h100));
      send_beat(write_req(KIND_WRITE_OLD, 32'hffffffff, 32'h1000, 20'h100));
      t = write_req(KIND_WRITE_OLD, 32'd4, 32'h1000, 20'h100);
      t.contents = CONTENTS_CONFORMING;
      t.absent = 1'b1;
      send_beat(t);
      t.kind = KIND_WRITE_NEW;
      t.absent = 1'b0;
      send_beat(t);
      send_beat(xlate_req(13'd0, 32'd0));
      t = write_req(KIND_WRITE_NEW, 32'd1, 32'h12345678, 20'hfffff);
      t.contents = CONTENTS_CONFORMING;
      t.absent = 1'b1;
      t.useable = 1'b1;
      send_beat(t);
      t = write_req(KIND_WRITE_OLD, TABLE_SIZE - 1, 32'hffffffff, 20'h00010);
      {t.no_write, t.operand_32, t.page_granular, t.useable} = 4'b1111;
      send_beat(t);
      send_beat(xlate_req(13'h1fff, 32'h00010fff));
      send_beat(xlate_req(13'h1fff, 32'h00010ffe));
      send_beat(xlate_req(13'd1, 32'hffffffff));
      send_beat(xlate_req(13'd1, 32'd0));
      t = write_req(KIND_WRITE_OLD, 32'd1, 32'd0, 20'd0);
      {t.no_write, t.operand_32} = 2'b01;
      send_beat(t);
      send_beat(xlate_req(13'd1, 32'd0));
      t = write_req(KIND_WRITE_NEW, 32'd2, 32'd0, 20'd0);
      {t.no_write, t.absent} = 2'b11;
      send_beat(t);
      t = write_req(KIND_WRITE_NEW, 32'd3, 32'd0, 20'd0);
      {t.no_write, t.absent, t.useable} = 3'b111;
      send_beat(t);
      send_beat(xlate_req(13'd3, 32'd0));
      send_beat(xlate_req(13'd2, 32'd0));
      t = xlate_req(13'd0, 32'd0);
      t.selector = 16'hfffe;
      send_beat(t);
      send_beat(xlate_req(13'h1fff, 32'd0));
      t = '1;
      t.kind = KIND_UNUSED;
      send_beat(t);
      drain_responses();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n >= RANDOM_ITEMS - CALM_TAIL);
         if (n == RANDOM_ITEMS / 2) drain_responses();
         if (!calm && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 4));
         send_beat(random_request());
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d accepted writes, %0d rejected or unused beats,",
               sb.writes_ok, sb.rejected);
      $display("and %0d translations (%0d over limit, %0d before any table).",
               sb.translations, sb.over_limit, sb.no_table);
      if (sb.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### files.f
+incdir+sv
sv/sdt_pkg.sv
sv/sdt_ctrl.sv
sv/sdt_dpath.sv
sv/segment_descriptor_table.sv
dv/testbench.sv
